FILE: rtl/cst_pkg.sv
// Shared types and constants of the counting semaphore table.
package cst_pkg;

   localparam int NumSemsDefault    = 32;
   localparam int CountWidthDefault = 16;
   localparam int OpcodeW           = 2;
   localparam int HandleW           = 6;
   localparam int InitW             = 16;
   localparam int QueueDepth        = 2;

   typedef enum logic [OpcodeW-1:0] {
      OP_OPEN  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_UP    = 2'd2,
      OP_DOWN  = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   reject;
   } cmd_type;

   typedef enum logic {
      BK_FETCH,
      BK_EXEC
   } bk_state_type;

endpackage

FILE: rtl/cst_ifs.sv
// Request and response channel interfaces of the counting semaphore table.
interface cst_req_if;
   import cst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OpcodeW-1:0]       opcode;
   logic [HandleW-1:0]       sem_handle;
   logic signed [InitW-1:0]  initial_count;

   modport source (output valid, output opcode, output sem_handle, output initial_count,
                   input ready);
   modport sink   (input valid, input opcode, input sem_handle, input initial_count,
                   output ready);
endinterface

interface cst_rsp_if;
   import cst_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [HandleW-1:0] handle_out;
   logic               wake;
   logic               blocked;

   modport source (output valid, output status, output handle_out, output wake,
                   output blocked, input ready);
   modport sink   (input valid, input status, input handle_out, input wake,
                   input blocked, output ready);
endinterface

FILE: rtl/cst_front.sv
// Request decoder and command queue ahead of the semaphore execution stage.
module cst_front #(
   parameter int NUM_SEMS    = cst_pkg::NumSemsDefault,
   parameter int COUNT_WIDTH = cst_pkg::CountWidthDefault,
   localparam int IdxW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   cst_req_if.sink                req_bus,
   output logic                   q_valid,
   input  logic                   q_ready,
   output cst_pkg::cmd_type       q_cmd,
   output logic [IdxW-1:0]        q_idx,
   output logic [COUNT_WIDTH-1:0] q_count
);
   import cst_pkg::*;

   localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillW = $clog2(QueueDepth + 1);
   localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

   cmd_type                 cmd_mem   [QueueDepth];
   logic [IdxW-1:0]         idx_mem   [QueueDepth];
   logic [COUNT_WIDTH-1:0]  count_mem [QueueDepth];

   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;

   op_type       op;
   logic         handle_bad;
   logic         count_bad;
   cmd_type      cmd;
   logic [8:0]   handle_less;
   logic [31:0]  init_wide;
   logic         push;
   logic         pop;

   // Classification depends only on the beat itself, never on table state.
   always_comb begin
      op          = op_type'(req_bus.opcode);
      handle_bad  = (req_bus.sem_handle == '0) ||
                    (9'(req_bus.sem_handle) > 9'(NUM_SEMS));
      count_bad   = req_bus.initial_count[InitW-1] ||
                    ({17'b0, req_bus.initial_count} > CountMax);
      cmd.op      = op;
      cmd.reject  = (op == OP_OPEN) ? count_bad : handle_bad;
      handle_less = 9'(req_bus.sem_handle) - 9'd1;
      init_wide   = {16'b0, req_bus.initial_count};
   end

   assign req_bus.ready = (fill_ff != FillW'(QueueDepth));
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (fill_ff != '0);
   assign pop           = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      fill_in = fill_ff + FillW'(push) - FillW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff]   <= cmd;
         idx_mem[wr_ptr_ff]   <= handle_less[IdxW-1:0];
         count_mem[wr_ptr_ff] <= init_wide[COUNT_WIDTH-1:0];
      end
   end

   assign q_cmd   = cmd_mem[rd_ptr_ff];
   assign q_idx   = idx_mem[rd_ptr_ff];
   assign q_count = count_mem[rd_ptr_ff];

endmodule

FILE: rtl/cst_back.sv
// Execution stage: slot flags, count memory and the response register.
module cst_back #(
   parameter int NUM_SEMS    = cst_pkg::NumSemsDefault,
   parameter int COUNT_WIDTH = cst_pkg::CountWidthDefault,
   localparam int IdxW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  cst_pkg::cmd_type       q_cmd,
   input  logic [IdxW-1:0]        q_idx,
   input  logic [COUNT_WIDTH-1:0] q_count,
   cst_rsp_if.source              rsp_bus
);
   import cst_pkg::*;

   bk_state_type state_ff, state_in;

   cmd_type                cmd_ff;
   logic [IdxW-1:0]        idx_ff;
   logic [COUNT_WIDTH-1:0] init_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic                   open_ff;
   logic [IdxW-1:0]        free_ff, free_in;
   logic                   full_ff, full_in;
   logic [NUM_SEMS-1:0]    slot_open_ff, slot_open_in;

   logic                   rsp_valid_ff;
   logic                   status_ff, status_in;
   logic [HandleW-1:0]     handle_ff, handle_in;
   logic                   wake_ff, wake_in;
   logic                   blocked_ff, blocked_in;

   logic [COUNT_WIDTH-1:0] count_mem [NUM_SEMS];

   logic                   fetch;
   logic                   exec_go;
   logic                   mem_we;
   logic [IdxW-1:0]        mem_addr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic [8:0]             handle_wide;

   // Lowest closed slot, taken while the command is fetched.
   always_comb begin
      free_in = '0;
      full_in = 1'b1;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!slot_open_ff[i]) begin
            free_in = IdxW'(i);
            full_in = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_FETCH: begin
            if (q_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = BK_FETCH;
            end
         end
         default: state_in = BK_FETCH;
      endcase
   end

   always_comb begin
      q_ready = 1'b0;
      exec_go = 1'b0;
      unique case (state_ff)
         BK_FETCH: q_ready = 1'b1;
         BK_EXEC:  exec_go = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            q_ready = 1'b0;
            exec_go = 1'b0;
         end
      endcase
   end

   assign fetch       = q_valid && q_ready;
   assign handle_wide = 9'(free_ff) + 9'd1;

   always_comb begin
      status_in    = 1'b0;
      handle_in    = '0;
      wake_in      = 1'b0;
      blocked_in   = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = idx_ff;
      mem_wdata    = cnt_ff;
      slot_open_in = slot_open_ff;
      if (cmd_ff.reject) begin
         status_in = 1'b1;
      end else begin
         unique case (cmd_ff.op)
            OP_OPEN: begin
               if (full_ff) begin
                  status_in = 1'b1;
               end else begin
                  slot_open_in[free_ff] = 1'b1;
                  mem_we                = 1'b1;
                  mem_addr              = free_ff;
                  mem_wdata             = init_ff;
                  handle_in             = handle_wide[HandleW-1:0];
               end
            end
            OP_CLOSE: begin
               slot_open_in[idx_ff] = 1'b0;
            end
            OP_UP: begin
               if (!open_ff || (cnt_ff == '1)) begin
                  status_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = cnt_ff + COUNT_WIDTH'(1);
                  wake_in   = (cnt_ff == '0);
               end
            end
            OP_DOWN: begin
               if (!open_ff) begin
                  status_in = 1'b1;
               end else if (cnt_ff == '0) begin
                  blocked_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = cnt_ff - COUNT_WIDTH'(1);
               end
            end
            default: status_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FETCH;
         slot_open_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            slot_open_ff <= slot_open_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         cmd_ff  <= q_cmd;
         idx_ff  <= q_idx;
         init_ff <= q_count;
         open_ff <= slot_open_ff[q_idx];
         free_ff <= free_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff  <= status_in;
         handle_ff  <= handle_in;
         wake_ff    <= wake_in;
         blocked_ff <= blocked_in;
      end
   end

   // Count memory: registered read on fetch, write-back on execute.
   always_ff @(posedge clock) begin
      if (fetch) begin
         cnt_ff <= count_mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && mem_we) begin
         count_mem[mem_addr] <= mem_wdata;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.handle_out = handle_ff;
   assign rsp_bus.wake       = wake_ff;
   assign rsp_bus.blocked    = blocked_ff;

endmodule

FILE: rtl/counting_semaphore_table.sv
// Top level of the counting semaphore table.
//
// Each request beat on req_bus carries an opcode (open, close, up, down), a
// 1-based handle and an initial count for open. Exactly one response beat
// follows on rsp_bus for every request, in order: status, the handle granted
// by open, a wake flag for an up from zero and a blocked flag for a down at
// zero.
// A request is decoded into a two-entry command queue; the execution stage
// then fetches the command, reads the count memory and finds the lowest
// closed slot in its fetch state, and writes back and loads the response
// register in its execute state. It takes no new command from the queue
// until the current one has been written back.
// If the receiver stalls, the response register holds its beat, the queue
// keeps accepting until it is full and then req_bus.ready falls.
// Synchronous reset closes every slot and empties the queue and the response
// register; counts are written by open before they are ever used.
module counting_semaphore_table #(
   parameter int NUM_SEMS    = cst_pkg::NumSemsDefault,
   parameter int COUNT_WIDTH = cst_pkg::CountWidthDefault
) (
   input logic       clock,
   input logic       reset,
   cst_req_if.sink   req_bus,
   cst_rsp_if.source rsp_bus
);
   import cst_pkg::*;

   localparam int IdxW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

   logic                   q_valid;
   logic                   q_ready;
   cmd_type                q_cmd;
   logic [IdxW-1:0]        q_idx;
   logic [COUNT_WIDTH-1:0] q_count;

   cst_front #(
      .NUM_SEMS    (NUM_SEMS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_cmd   (q_cmd),
      .q_idx   (q_idx),
      .q_count (q_count)
   );

   cst_back #(
      .NUM_SEMS    (NUM_SEMS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_cmd   (q_cmd),
      .q_idx   (q_idx),
      .q_count (q_count),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("Response beat present straight after reset.");

   a_handle_only_on_success: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.handle_out != '0) |->
         !rsp_bus.status && !rsp_bus.wake && !rsp_bus.blocked)
      else $error("Granted handle returned with an error or a flag.");

   a_flags_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.wake || rsp_bus.blocked) |->
         !rsp_bus.status && (rsp_bus.handle_out == '0) &&
         !(rsp_bus.wake && rsp_bus.blocked))
      else $error("Wake or blocked flag raised with a conflicting field.");

   a_fetch_then_execute: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> !q_ready)
      else $error("Execution stage fetched two commands in consecutive cycles.");
`endif

endmodule
